/* rtl/ipq_pkg.sv */
// ----------------------------------------------------------------------------
// ipq_pkg
// Shared types, codes and defaults of the indexed priority queue.
// ----------------------------------------------------------------------------
package ipq_pkg;

  localparam int unsigned CAPACITY_DEF  = 1024;
  localparam int unsigned ID_SPACE_DEF  = 4096;
  localparam int unsigned PRI_BITS_DEF  = 16;

  localparam int unsigned ID_FW     = 12;
  localparam int unsigned PRI_FW    = 16;
  localparam int unsigned CNT_FW    = 11;
  localparam int unsigned STATUS_FW = 3;
  localparam int unsigned CFG_AW    = 3;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_TOGGLE  = 2'd2,
    OP_DEQUEUE = 2'd3
  } op_e;

  typedef enum logic [STATUS_FW-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DUP      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DQ,
    S_LOAD,
    S_UP,
    S_UPC,
    S_DN,
    S_DNL,
    S_DNR,
    S_FIN,
    S_RES
  } eng_state_e;

  typedef struct packed {
    op_e               op;
    logic [ID_FW-1:0]  id;
    logic [PRI_FW-1:0] pri;
    logic              tk;
    logic              in_space;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [ID_FW-1:0]  id;
    logic [PRI_FW-1:0] pri;
    logic              tk;
    logic [CNT_FW-1:0] count;
  } res_t;

endpackage

/* rtl/ipq_fifo.sv */
// ----------------------------------------------------------------------------
// ipq_fifo
// Two-entry queue that decouples the sides of the priority queue.
// ----------------------------------------------------------------------------
module ipq_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wp_q, wp_d, rp_q, rp_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = do_push ? !wp_q : wp_q;
    rp_d  = do_pop ? !rp_q : rp_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

/* rtl/ipq_front.sv */
// ----------------------------------------------------------------------------
// ipq_front
// Request intake: classifies each request and queues it for the engine.
// ----------------------------------------------------------------------------
module ipq_front #(
  parameter int unsigned ID_SPACE = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [1:0]               req_type_i,
  input  logic [ipq_pkg::ID_FW-1:0]  entry_id_i,
  input  logic [ipq_pkg::PRI_FW-1:0] entry_priority_i,
  input  logic                     entry_takeaway_i,
  output logic                     full_o,
  output logic                     req_valid_o,
  output ipq_pkg::req_t            req_o,
  input  logic                     req_pop_i
);
  import ipq_pkg::*;

  req_t req_in;
  logic q_empty;

  always_comb begin
    req_in.op       = op_e'(req_type_i);
    req_in.id       = entry_id_i;
    req_in.pri      = entry_priority_i;
    req_in.tk       = entry_takeaway_i;
    req_in.in_space = (32'(entry_id_i) < ID_SPACE);
  end

  ipq_fifo #(.WIDTH($bits(req_t))) u_reqq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (req_in),
    .full_o  (full_o),
    .pop_i   (req_pop_i),
    .data_o  (req_o),
    .empty_o (q_empty)
  );

  assign req_valid_o = !q_empty;

endmodule

/* rtl/ipq_engine.sv */
// ----------------------------------------------------------------------------
// ipq_engine
// Heap sequencer: id lookup, sift up and sift down over the heap memory.
// ----------------------------------------------------------------------------
module ipq_engine #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned ID_SPACE = 4096,
  parameter int unsigned PRIORITY_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [ipq_pkg::CNT_FW-1:0] cap_limit_i,
  input  logic                      req_valid_i,
  input  ipq_pkg::req_t             req_i,
  output logic                      req_pop_o,
  output logic                      clearing_o,
  output logic                      res_valid_o,
  output ipq_pkg::res_t             res_o,
  input  logic                      res_full_i
);
  import ipq_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W  = $clog2(ID_SPACE);
  localparam int unsigned PRI_W = PRIORITY_BITS;

  typedef struct packed {
    logic [ID_FW-1:0] id;
    logic [PRI_W-1:0] pri;
    logic             tk;
  } ent_t;

  function automatic logic ahead(ent_t a, ent_t b);
    logic r;
    if (a.pri != b.pri) begin
      r = (a.pri < b.pri);
    end else if (a.tk != b.tk) begin
      r = a.tk;
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

  ent_t             heap_mem [CAPACITY];
  logic [CNT_W-1:0] slot_mem [ID_SPACE];

  eng_state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [ID_W-1:0]  clr_q, clr_d;
  req_t             req_q, req_d;
  ent_t             cur_q, cur_d, lch_q, lch_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  status_e          status_q, status_d;
  ent_t             out_q, out_d;

  ent_t             heap_rd, heap_wd;
  logic [IDX_W-1:0] heap_ra, heap_wa;
  logic             heap_we;
  logic [CNT_W-1:0] slot_rd, slot_wd;
  logic [ID_W-1:0]  slot_ra, slot_wa;
  logic             slot_we;

  logic [IDX_W:0]   l_idx;
  logic [IDX_W+1:0] r_idx;
  logic             l_in, r_in, clr_last, ins_full, slot_ok;
  logic             up_move, l_win_dnl, lwin, rwin;
  ent_t             cand;

  assign l_idx    = {pos_q, 1'b1};
  assign r_idx    = (IDX_W + 2)'(l_idx) + (IDX_W + 2)'(1);
  assign l_in     = 32'(l_idx) < 32'(count_q);
  assign r_in     = 32'(r_idx) < 32'(count_q);
  assign clr_last = (clr_q == ID_W'(ID_SPACE - 1));
  assign ins_full = (32'(cap_limit_i) > CAPACITY) ? (32'(count_q) >= CAPACITY)
                                                  : (32'(count_q) >= 32'(cap_limit_i));
  assign slot_ok  = req_q.in_space && (slot_rd != '0) && (slot_rd <= count_q);
  assign up_move  = ahead(cur_q, heap_rd);
  assign l_win_dnl = ahead(heap_rd, cur_q);
  assign lwin     = ahead(lch_q, cur_q);
  assign cand     = lwin ? lch_q : cur_q;
  assign rwin     = ahead(heap_rd, cand);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_last) state_d = S_IDLE;
      S_IDLE:  if (req_valid_i) state_d = S_LOOK;
      S_LOOK: begin
        unique case (req_q.op)
          OP_INSERT: begin
            if (ins_full || !req_q.in_space || slot_rd != '0) state_d = S_RES;
            else state_d = S_UP;
          end
          OP_REMOVE: begin
            if (!slot_ok || slot_rd == count_q) state_d = S_RES;
            else state_d = S_LOAD;
          end
          OP_TOGGLE: state_d = slot_ok ? S_LOAD : S_RES;
          OP_DEQUEUE: state_d = (count_q == '0) ? S_RES : S_DQ;
          default: state_d = S_RES;
        endcase
      end
      S_DQ:   state_d = (count_q == CNT_W'(1)) ? S_RES : S_LOAD;
      S_LOAD: state_d = S_UP;
      S_UP:   state_d = (pos_q == '0) ? S_DN : S_UPC;
      S_UPC:  state_d = up_move ? S_UP : S_DN;
      S_DN:   state_d = l_in ? S_DNL : S_FIN;
      S_DNL: begin
        if (r_in) state_d = S_DNR;
        else state_d = l_win_dnl ? S_DN : S_FIN;
      end
      S_DNR:  state_d = (rwin || lwin) ? S_DN : S_FIN;
      S_FIN:  state_d = S_RES;
      S_RES:  if (!res_full_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    clr_d     = clr_q;
    req_d     = req_q;
    cur_d     = cur_q;
    lch_d     = lch_q;
    pos_d     = pos_q;
    status_d  = status_q;
    out_d     = out_q;
    heap_ra   = '0;
    heap_we   = 1'b0;
    heap_wa   = pos_q;
    heap_wd   = cur_q;
    slot_ra   = ID_W'(req_i.id);
    slot_we   = 1'b0;
    slot_wa   = ID_W'(cur_q.id);
    slot_wd   = CNT_W'(pos_q) + CNT_W'(1);
    req_pop_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        slot_we = 1'b1;
        slot_wa = clr_q;
        slot_wd = '0;
        clr_d   = clr_q + ID_W'(1);
      end
      S_IDLE: begin
        req_pop_o = req_valid_i;
        req_d     = req_i;
        status_d  = ST_OK;
        out_d     = '0;
      end
      S_LOOK: begin
        unique case (req_q.op)
          OP_INSERT: begin
            if (ins_full) begin
              status_d = ST_FULL;
            end else if (!req_q.in_space) begin
              status_d = ST_NOTFOUND;
            end else if (slot_rd != '0) begin
              status_d = ST_DUP;
            end else begin
              cur_d.id  = req_q.id;
              cur_d.pri = PRI_W'(req_q.pri);
              cur_d.tk  = req_q.tk;
              pos_d     = IDX_W'(count_q);
              count_d   = count_q + CNT_W'(1);
            end
          end
          OP_REMOVE: begin
            if (!slot_ok) begin
              status_d = ST_NOTFOUND;
            end else begin
              slot_we = 1'b1;
              slot_wa = ID_W'(req_q.id);
              slot_wd = '0;
              count_d = count_q - CNT_W'(1);
              pos_d   = IDX_W'(slot_rd - CNT_W'(1));
              heap_ra = IDX_W'(count_q - CNT_W'(1));
            end
          end
          OP_TOGGLE: begin
            if (!slot_ok) begin
              status_d = ST_NOTFOUND;
            end else begin
              pos_d   = IDX_W'(slot_rd - CNT_W'(1));
              heap_ra = IDX_W'(slot_rd - CNT_W'(1));
            end
          end
          OP_DEQUEUE: begin
            if (count_q == '0) status_d = ST_EMPTY;
            else heap_ra = '0;
          end
          default: status_d = ST_OK;
        endcase
      end
      S_DQ: begin
        out_d   = heap_rd;
        slot_we = 1'b1;
        slot_wa = ID_W'(heap_rd.id);
        slot_wd = '0;
        count_d = count_q - CNT_W'(1);
        pos_d   = '0;
        heap_ra = IDX_W'(count_q - CNT_W'(1));
      end
      S_LOAD: begin
        cur_d = heap_rd;
        if (req_q.op == OP_TOGGLE) cur_d.tk = !heap_rd.tk;
      end
      S_UP: begin
        heap_ra = IDX_W'((pos_q - IDX_W'(1)) >> 1);
      end
      S_UPC: begin
        if (up_move) begin
          heap_we = 1'b1;
          heap_wd = heap_rd;
          slot_we = 1'b1;
          slot_wa = ID_W'(heap_rd.id);
          pos_d   = IDX_W'((pos_q - IDX_W'(1)) >> 1);
        end
      end
      S_DN: begin
        heap_ra = IDX_W'(l_idx);
      end
      S_DNL: begin
        if (r_in) begin
          lch_d   = heap_rd;
          heap_ra = IDX_W'(r_idx);
        end else if (l_win_dnl) begin
          heap_we = 1'b1;
          heap_wd = heap_rd;
          slot_we = 1'b1;
          slot_wa = ID_W'(heap_rd.id);
          pos_d   = IDX_W'(l_idx);
        end
      end
      S_DNR: begin
        if (rwin) begin
          heap_we = 1'b1;
          heap_wd = heap_rd;
          slot_we = 1'b1;
          slot_wa = ID_W'(heap_rd.id);
          pos_d   = IDX_W'(r_idx);
        end else if (lwin) begin
          heap_we = 1'b1;
          heap_wd = lch_q;
          slot_we = 1'b1;
          slot_wa = ID_W'(lch_q.id);
          pos_d   = IDX_W'(l_idx);
        end
      end
      S_FIN: begin
        heap_we = 1'b1;
        slot_we = 1'b1;
      end
      S_RES: begin
        heap_ra = '0;
      end
      default: heap_ra = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      count_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    cur_q    <= cur_d;
    lch_q    <= lch_d;
    pos_q    <= pos_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_rd <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    slot_rd <= slot_mem[slot_ra];
  end

  assign clearing_o   = (state_q == S_CLEAR);
  assign res_valid_o  = (state_q == S_RES);
  assign res_o.status = status_q;
  assign res_o.id     = out_q.id;
  assign res_o.pri    = PRI_FW'(out_q.pri);
  assign res_o.tk     = out_q.tk;
  assign res_o.count  = CNT_FW'(count_q);

endmodule

/* rtl/indexed_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// indexed_priority_queue_top
// Indexed binary min-heap with id lookup, served as a request/result queue.
// ----------------------------------------------------------------------------
// Requests enter through push/full: insert, remove by id, toggle the takeaway
// flag of an id, or dequeue the minimum (lower priority, then takeaway, then
// lower id). Each request yields one result on empty/pop, in request order.
// A two-entry request queue and a two-entry result queue sit around the heap
// engine, so requests keep flowing in while a result waits to be popped.
// A request that sifts moves one heap level at a time, going up and going down,
// since the heap memory has one read port and gives one read per cycle. Each
// request passes through the engine's idle state before the next is taken.
// After reset the engine clears the id table, one entry per cycle, with full
// held high; configuration writes are taken meanwhile.
// A stalled result queue holds the engine on its finished result; requests
// queue up until full rises.
// capacity_limit lies at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module indexed_priority_queue_top #(
  parameter int unsigned CAPACITY      = ipq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_SPACE      = ipq_pkg::ID_SPACE_DEF,
  parameter int unsigned PRIORITY_BITS = ipq_pkg::PRI_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    req_type_i,
  input  logic [ipq_pkg::ID_FW-1:0]     entry_id_i,
  input  logic [ipq_pkg::PRI_FW-1:0]    entry_priority_i,
  input  logic                          entry_takeaway_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [ipq_pkg::STATUS_FW-1:0] status_o,
  output logic [ipq_pkg::ID_FW-1:0]     out_id_o,
  output logic [ipq_pkg::PRI_FW-1:0]    out_priority_o,
  output logic                          out_takeaway_o,
  output logic [ipq_pkg::CNT_FW-1:0]    entry_count_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ipq_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ipq_pkg::*;

  logic [CNT_FW-1:0] cap_q;
  logic              reg_hit, req_full, clearing, front_push;
  logic              req_valid, req_pop, res_valid, res_full;
  req_t              req;
  res_t              res, res_head;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_AW-1] == 1'b0);
  assign prdata  = reg_hit ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CNT_FW'(1024);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      cap_q <= pwdata[CNT_FW-1:0];
    end
  end

  assign full       = req_full || clearing;
  assign front_push = push && !full;

  ipq_front #(.ID_SPACE(ID_SPACE)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (front_push),
    .req_type_i       (req_type_i),
    .entry_id_i       (entry_id_i),
    .entry_priority_i (entry_priority_i),
    .entry_takeaway_i (entry_takeaway_i),
    .full_o           (req_full),
    .req_valid_o      (req_valid),
    .req_o            (req),
    .req_pop_i        (req_pop)
  );

  ipq_engine #(
    .CAPACITY      (CAPACITY),
    .ID_SPACE      (ID_SPACE),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_limit_i (cap_q),
    .req_valid_i (req_valid),
    .req_i       (req),
    .req_pop_o   (req_pop),
    .clearing_o  (clearing),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  ipq_fifo #(.WIDTH($bits(res_t))) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_head),
    .empty_o (empty)
  );

  assign status_o       = res_head.status;
  assign out_id_o       = res_head.id;
  assign out_priority_o = res_head.pri;
  assign out_takeaway_o = res_head.tk;
  assign entry_count_o  = res_head.count;

endmodule

/* rtl/ipq_checker.sv */
// ----------------------------------------------------------------------------
// ipq_checker
// Port-level checks of the indexed priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module ipq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          empty,
  input logic                          pop,
  input logic [ipq_pkg::STATUS_FW-1:0] status_o,
  input logic [ipq_pkg::ID_FW-1:0]     out_id_o,
  input logic [ipq_pkg::PRI_FW-1:0]    out_priority_o,
  input logic                          out_takeaway_o,
  input logic [ipq_pkg::CNT_FW-1:0]    entry_count_o
);
  import ipq_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(status_o) && $stable(out_id_o)
                          && $stable(entry_count_o)))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_OK || status_o == ST_FULL || status_o == ST_EMPTY
                || status_o == ST_NOTFOUND || status_o == ST_DUP))
    else $error("unknown status code");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_EMPTY) |->
      (out_id_o == '0 && out_priority_o == '0 && !out_takeaway_o
       && entry_count_o == '0))
    else $error("empty dequeue carries entry data");

  a_refused_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |->
      (out_id_o == '0 && out_priority_o == '0 && !out_takeaway_o))
    else $error("refused request carries entry data");

endmodule

bind indexed_priority_queue_top ipq_checker u_ipq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty          (empty),
  .pop            (pop),
  .status_o       (status_o),
  .out_id_o       (out_id_o),
  .out_priority_o (out_priority_o),
  .out_takeaway_o (out_takeaway_o),
  .entry_count_o  (entry_count_o)
);

/* tb/sv/tb_indexed_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// tb_indexed_priority_queue_top
// Self-checking bench for the indexed priority queue.
// ----------------------------------------------------------------------------
// A mirror heap with its own id table predicts every response. Directed
// requests cover empty, absent, duplicate and extreme cases. Random phases
// then run under several capacity limits and handshake idling patterns.
// Responses are compared field by field in request order.
// ----------------------------------------------------------------------------
module tb_indexed_priority_queue_top;
  import ipq_pkg::*;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned ID_COUNT   = 4096;
  localparam int unsigned CYCLE_CAP  = 400000;

  class heap_mirror;
    logic [ID_FW-1:0]  slot_id  [HEAP_DEPTH];
    logic [PRI_FW-1:0] slot_pri [HEAP_DEPTH];
    logic              slot_tk  [HEAP_DEPTH];
    int unsigned       id_slot  [ID_COUNT];
    int unsigned       held;
    int unsigned       cap_limit;
    res_t              due_results[$];
    int unsigned       errors;

    function new();
      held = 0;
      cap_limit = 1024;
      errors = 0;
      foreach (id_slot[i]) id_slot[i] = 0;
    endfunction

    function bit ahead(int unsigned a, int unsigned b);
      if (slot_pri[a] != slot_pri[b]) return slot_pri[a] < slot_pri[b];
      if (slot_tk[a] != slot_tk[b]) return slot_tk[a];
      return slot_id[a] < slot_id[b];
    endfunction

    function void place(int unsigned s, logic [ID_FW-1:0] id, logic [PRI_FW-1:0] pri,
                        logic tk);
      slot_id[s] = id;
      slot_pri[s] = pri;
      slot_tk[s] = tk;
      id_slot[id] = s + 1;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [ID_FW-1:0]  id;
      logic [PRI_FW-1:0] pri;
      logic              tk;
      id = slot_id[a];
      pri = slot_pri[a];
      tk = slot_tk[a];
      place(a, slot_id[b], slot_pri[b], slot_tk[b]);
      place(b, id, pri, tk);
    endfunction

    function int unsigned rise(int unsigned i);
      int unsigned p;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (!ahead(i, p)) break;
        swap_slots(i, p);
        i = p;
      end
      return i;
    endfunction

    function void sink(int unsigned i);
      int unsigned l, r, best;
      forever begin
        l = 2 * i + 1;
        r = l + 1;
        best = i;
        if (l < held && ahead(l, best)) best = l;
        if (r < held && ahead(r, best)) best = r;
        if (best == i) break;
        swap_slots(i, best);
        i = best;
      end
    endfunction

    function void extract(int unsigned i);
      int unsigned last;
      last = held - 1;
      id_slot[slot_id[i]] = 0;
      held = last;
      if (i != last) begin
        place(i, slot_id[last], slot_pri[last], slot_tk[last]);
        i = rise(i);
        sink(i);
      end
    endfunction

    function void note_request(op_e op, logic [ID_FW-1:0] id, logic [PRI_FW-1:0] pri,
                               logic tk);
      res_t        r;
      int unsigned lim, s, i;
      r = '0;
      r.status = ST_OK;
      lim = (cap_limit > HEAP_DEPTH) ? HEAP_DEPTH : cap_limit;
      s = id_slot[id];
      case (op)
        OP_INSERT: begin
          if (held >= lim) r.status = ST_FULL;
          else if (s != 0) r.status = ST_DUP;
          else begin
            place(held, id, pri, tk);
            held++;
            void'(rise(held - 1));
          end
        end
        OP_REMOVE: begin
          if (s == 0 || s > held) r.status = ST_NOTFOUND;
          else extract(s - 1);
        end
        OP_TOGGLE: begin
          if (s == 0 || s > held) r.status = ST_NOTFOUND;
          else begin
            i = s - 1;
            slot_tk[i] = ~slot_tk[i];
            i = rise(i);
            sink(i);
          end
        end
        default: begin
          if (held == 0) r.status = ST_EMPTY;
          else begin
            r.id = slot_id[0];
            r.pri = slot_pri[0];
            r.tk = slot_tk[0];
            extract(0);
          end
        end
      endcase
      r.count = held[CNT_FW-1:0];
      due_results.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [STATUS_FW-1:0] st, logic [ID_FW-1:0] id,
                      logic [PRI_FW-1:0] pri, logic tk, logic [CNT_FW-1:0] cnt);
      res_t e;
      if (due_results.size() == 0) begin
        report("response with no request outstanding");
      end else begin
        e = due_results.pop_front();
        if (st !== e.status) report($sformatf("status %0d, want %0d", st, e.status));
        if (id !== e.id) report($sformatf("out_id %0d, want %0d", id, e.id));
        if (pri !== e.pri) report($sformatf("out_priority %0d, want %0d", pri, e.pri));
        if (tk !== e.tk) report($sformatf("out_takeaway %0d, want %0d", tk, e.tk));
        if (cnt !== e.count) report($sformatf("entry_count %0d, want %0d", cnt, e.count));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [1:0]           req_type_i;
  logic [ID_FW-1:0]     entry_id_i;
  logic [PRI_FW-1:0]    entry_priority_i;
  logic                 entry_takeaway_i;
  logic                 empty;
  logic                 pop;
  logic [STATUS_FW-1:0] status_o;
  logic [ID_FW-1:0]     out_id_o;
  logic [PRI_FW-1:0]    out_priority_o;
  logic                 out_takeaway_o;
  logic [CNT_FW-1:0]    entry_count_o;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  heap_mirror  mirror;
  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  int unsigned cycles;

  indexed_priority_queue_top dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      mirror.check_result(status_o, out_id_o, out_priority_o, out_takeaway_o, entry_count_o);
    pop <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  task cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == 0) mirror.cap_limit = data & 32'h7FF;
  endtask

  task send(op_e op, logic [ID_FW-1:0] id, logic [PRI_FW-1:0] pri, logic tk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    push <= 1'b1;
    req_type_i <= op;
    entry_id_i <= id;
    entry_priority_i <= pri;
    entry_takeaway_i <= tk;
    do @(posedge clk_i); while (full);
    mirror.note_request(op, id, pri, tk);
  endtask

  task drain;
    if (push) push <= 1'b0;
    while (mirror.due_results.size() != 0) @(posedge clk_i);
  endtask

  task send_random;
    int unsigned k;
    op_e         op;
    logic [ID_FW-1:0]  id;
    logic [PRI_FW-1:0] pri;
    k = $urandom_range(0, 99);
    op = (k < 40) ? OP_INSERT : (k < 65) ? OP_DEQUEUE : (k < 85) ? OP_REMOVE : OP_TOGGLE;
    id = ($urandom_range(0, 9) == 0) ? ID_FW'($urandom_range(0, ID_COUNT - 1))
                                      : ID_FW'($urandom_range(0, 23));
    pri = ($urandom_range(0, 3) == 0) ? PRI_FW'($urandom_range(0, 65535))
                                       : PRI_FW'($urandom_range(0, 7));
    send(op, id, pri, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int unsigned limits[8] = '{2047, 0, 1, 6, 1024, 40, 3, 1024};
    mirror = new();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    rst_ni <= 1'b0;
    push <= 1'b0;
    req_type_i <= OP_INSERT;
    entry_id_i <= '0;
    entry_priority_i <= '0;
    entry_takeaway_i <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(OP_DEQUEUE, '0, '0, 1'b0);
    send(OP_REMOVE, 12'd4095, '0, 1'b0);
    send(OP_TOGGLE, 12'd7, '0, 1'b0);
    send(OP_INSERT, 12'd4095, 16'hFFFF, 1'b1);
    send(OP_INSERT, 12'd0, 16'hFFFF, 1'b0);
    send(OP_INSERT, 12'd5, 16'd0, 1'b0);
    send(OP_INSERT, 12'd6, 16'd0, 1'b1);
    send(OP_INSERT, 12'd2730, 16'hAAAA, 1'b0);
    send(OP_INSERT, 12'd1365, 16'h5555, 1'b1);
    send(OP_INSERT, 12'd5, 16'd9, 1'b1);
    send(OP_TOGGLE, 12'd5, '0, 1'b0);
    send(OP_TOGGLE, 12'd0, '0, 1'b0);
    send(OP_REMOVE, 12'd2730, '0, 1'b0);
    send(OP_REMOVE, 12'd2730, '0, 1'b0);
    repeat (6) send(OP_DEQUEUE, '0, '0, 1'b0);
    drain();
    cfg_write(3'd4, 32'd2);
    cfg_write(3'd0, 32'd1);
    send(OP_INSERT, 12'd3, 16'd1, 1'b0);
    send(OP_INSERT, 12'd3, 16'd1, 1'b0);
    send(OP_DEQUEUE, '0, '0, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(3'd0, limits[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
        1: begin send_idle_pct = 71; pop_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  pop_stall_pct = 71; end
        default: begin send_idle_pct = 35; pop_stall_pct = 35; end
      endcase
      repeat (80) send_random();
      drain();
    end

    repeat (40) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ipq_pkg.sv
rtl/ipq_fifo.sv
rtl/ipq_front.sv
rtl/ipq_engine.sv
rtl/indexed_priority_queue_top.sv
rtl/ipq_checker.sv
tb/sv/tb_indexed_priority_queue_top.sv
